/* sv/rdsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and constants for the radix digit string converter
// Widths, opcodes and the item formats passed between front, converter and
// character emitter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int VALUE_W       = 64;
    localparam int OP_W          = 2;
    localparam int DIGIT_COUNT   = 16;
    localparam int DIG_W         = 4 * DIGIT_COUNT;
    localparam int EXT_W         = VALUE_W + DIG_W;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS + 1);
    localparam int CNT_W         = $clog2(DIGIT_COUNT + 1);
    localparam int CHAR_W        = 7;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_W    = ((VALUE_W + OP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((CHAR_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0] LOWER_HEX_OFFSET = 7'd39;
    localparam logic [CHAR_W-1:0] UPPER_HEX_OFFSET = 7'd7;
    localparam logic [3:0]        MAX_DEC_DIGIT    = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_OCT    = 2'd0,
        OP_DEC    = 2'd1,
        OP_HEX_LO = 2'd2,
        OP_HEX_UP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX
    } t_radix;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_radix             radix;
        logic               upper;
    } t_job;

    typedef struct packed {
        logic [DIG_W-1:0] nib;
        logic             upper;
    } t_digits;

endpackage

/* sv/radix_digit_string_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_converter: 64-bit value to fixed-width ASCII digit run
// Emits DIGIT_COUNT characters per item, most significant first, zero padded,
// in octal, decimal, lowercase hex or uppercase hex.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  s       | in        | i_s_tvalid / o_s_tready  | i_s_tdata: value, opcode
//  m       | out       | o_m_tvalid / i_m_tready  | o_m_tdata: digit_char; o_m_tlast
//
//  One item yields 16 characters at one per cycle while the output is not
//  stalled. The decimal converter folds 4 value bits per cycle and converts
//  the next item while the current one is emitted. The first character passes
//  the converter register, after all decimal steps, then the output register.
//  Reset (synchronous, active low) empties the queue and drops any item in
//  flight. A stall on the output holds the current character; the 2-entry
//  queue keeps the input open while a conversion or emission is pending.
//
module radix_digit_string_converter
    import rdsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [63:0] value, [65:64] opcode, rest zero
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [6:0] digit_char, [7] zero
    output logic                   o_m_tlast
);

    logic              w_job_valid;
    t_job              w_job;
    logic              w_job_pop;
    logic              w_res_valid;
    t_digits           w_res;
    logic              w_res_ready;
    logic [CHAR_W-1:0] w_char;

    // Front: classify the opcode and queue the job.
    rdsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_value     (i_s_tdata[VALUE_W-1:0]),
        .i_op        (t_op'(i_s_tdata[VALUE_W +: OP_W])),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // Back, first half: produce the digit nibbles.
    rdsc_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // Back, second half: serialize to ASCII; the next digit set is taken
    // in the same cycle the final character of the previous one is handed out.
    rdsc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_char      (w_char),
        .o_last      (o_m_tlast)
    );

    // Pad the 7-bit character to a whole byte.
    assign o_m_tdata = {{(OUT_TDATA_W - CHAR_W){1'b0}}, w_char};

endmodule

/* sv/rdsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_front: input acceptance, opcode classification and job queue
// Decodes the opcode into radix and letter case, then holds jobs in a short
// queue until the converter pulls them.
// ----------------------------------------------------------------------------
module rdsc_front
    import rdsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_value,
    input  t_op                i_op,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_job_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_job              w_job;
    logic              w_wr;
    logic              w_rd;

    always_comb begin
        w_job.value = i_value;
        w_job.upper = 1'b0;
        case (i_op)
            OP_OCT:    w_job.radix = RADIX_OCT;
            OP_DEC:    w_job.radix = RADIX_DEC;
            OP_HEX_LO: w_job.radix = RADIX_HEX;
            OP_HEX_UP: begin
                w_job.radix = RADIX_HEX;
                w_job.upper = 1'b1;
            end
            default:   w_job.radix = RADIX_HEX;
        endcase
    end

    assign o_s_tready  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_mem[r_rp];
    assign w_wr        = i_s_tvalid && o_s_tready;
    assign w_rd        = i_job_pop && o_job_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_job;
        end
    end

endmodule

/* sv/rdsc_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_conv: digit extraction unit
// Octal and hex split the value into digit nibbles directly; octal keeps only
// the low DIGIT_COUNT digits. Decimal runs shift-and-add-3, four bits per cycle,
// keeping only the low DIGIT_COUNT BCD digits (top carry drops: modulo 10^n).
// ----------------------------------------------------------------------------
module rdsc_conv
    import rdsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_res_valid,
    output t_digits o_res,
    input  logic    i_res_ready
);

    logic               r_busy, n_busy;
    logic               r_have, n_have;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [DIG_W-1:0]   r_bcd, n_bcd;
    logic               r_upper, n_upper;
    logic [EXT_W-1:0]   w_ext;
    logic               w_take;
    logic               w_free;

    function automatic logic [DIG_W-1:0] bcd_step(
        input logic [DIG_W-1:0]         bcd,
        input logic [BITS_PER_STEP-1:0] bits
    );
        logic [DIG_W-1:0] acc;
        acc = bcd;
        for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                if (acc[4*d +: 4] > 4'd4) begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[DIG_W-2:0], bits[k]};
        end
        return acc;
    endfunction

    function automatic logic [DIG_W-1:0] split_oct(input logic [EXT_W-1:0] v);
        logic [DIG_W-1:0] d;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            d[4*i +: 4] = {1'b0, v[3*i +: 3]};
        end
        return d;
    endfunction

    assign w_ext       = {{DIG_W{1'b0}}, i_job.value};
    assign o_res_valid = r_have;
    assign o_res.nib   = r_bcd;
    assign o_res.upper = r_upper;
    assign w_take      = r_have && i_res_ready;
    assign w_free      = !r_busy && (!r_have || w_take);
    assign o_job_pop   = w_free && i_job_valid;

    always_comb begin
        n_busy  = r_busy;
        n_have  = r_have && !w_take;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_upper = r_upper;
        if (r_busy) begin
            n_bcd = bcd_step(r_bcd, r_bin[VALUE_W-1 -: BITS_PER_STEP]);
            n_bin = {r_bin[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_have = 1'b1;
            end
        end else if (o_job_pop) begin
            n_upper = i_job.upper;
            case (i_job.radix)
                RADIX_DEC: begin
                    // first four bits go in on the load cycle
                    n_bcd  = bcd_step('0, i_job.value[VALUE_W-1 -: BITS_PER_STEP]);
                    n_bin  = {i_job.value[VALUE_W-BITS_PER_STEP-1:0],
                              {BITS_PER_STEP{1'b0}}};
                    n_cnt  = STEP_W'(CONV_STEPS - 1);
                    n_busy = 1'b1;
                    n_have = 1'b0;
                end
                RADIX_OCT: begin
                    n_bcd  = split_oct(w_ext);
                    n_have = 1'b1;
                end
                default: begin
                    n_bcd  = w_ext[DIG_W-1:0];
                    n_have = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_have <= n_have;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_upper <= n_upper;
    end

endmodule

/* sv/rdsc_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_emit: character serializer
// Shifts digit nibbles out most significant first, maps each to ASCII and
// holds it in the output register until taken.
// ----------------------------------------------------------------------------
module rdsc_emit
    import rdsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  t_digits           i_res,
    output logic              o_res_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic              r_vld, n_vld;
    logic              r_lst, n_lst;
    logic [CHAR_W-1:0] r_chr, n_chr;
    logic [DIG_W-1:0]  r_rest, n_rest;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic              r_upper, n_upper;
    logic              w_adv;

    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + CHAR_W'(d);
        if (d > MAX_DEC_DIGIT) begin
            c = c + (upper ? UPPER_HEX_OFFSET : LOWER_HEX_OFFSET);
        end
        return c;
    endfunction

    assign w_adv       = !r_vld || i_m_tready;
    assign o_res_ready = w_adv && (r_rem == '0);
    assign o_m_tvalid  = r_vld;
    assign o_char      = r_chr;
    assign o_last      = r_lst;

    always_comb begin
        n_vld   = r_vld;
        n_lst   = r_lst;
        n_chr   = r_chr;
        n_rest  = r_rest;
        n_rem   = r_rem;
        n_upper = r_upper;
        if (w_adv) begin
            if (r_rem != '0) begin
                n_chr  = glyph(r_rest[DIG_W-1 -: 4], r_upper);
                n_rest = r_rest << 4;
                n_rem  = r_rem - 1'b1;
                n_lst  = (r_rem == CNT_W'(1));
                n_vld  = 1'b1;
            end else if (i_res_valid) begin
                n_chr   = glyph(i_res.nib[DIG_W-1 -: 4], i_res.upper);
                n_rest  = i_res.nib << 4;
                n_rem   = CNT_W'(DIGIT_COUNT - 1);
                n_lst   = (DIGIT_COUNT == 1);
                n_upper = i_res.upper;
                n_vld   = 1'b1;
            end else begin
                n_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_rem <= '0;
        end else begin
            r_vld <= n_vld;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lst   <= n_lst;
        r_chr   <= n_chr;
        r_rest  <= n_rest;
        r_upper <= n_upper;
    end

endmodule
